// ----- sv/beng_pkg.sv -----
// ----------------------------------------------------------------------------
// beng_pkg
// Shared types and constants of the block-energy noise gate.
// ----------------------------------------------------------------------------
package beng_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int BLOCK_FRAMES = 64;

  localparam int CNT_W  = $clog2(BLOCK_FRAMES + 1);
  localparam int ADDR_W = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W = 2 * SAMPLE_BITS + 5;

  localparam int CHN_W = 2;
  localparam int THR_W = 27;
  localparam int ATK_W = 13;
  localparam int REL_W = 17;
  localparam int CFG_W = 27;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [IDX_W-1:0] REG_THRESH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ATTACK   = 2'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE  = 2'd3;

  localparam logic [CHN_W-1:0] CHN_RESET = 2'd2;
  localparam logic [THR_W-1:0] THR_RESET = 27'd1073742;
  localparam logic [ATK_W-1:0] ATK_RESET = 13'd655;
  localparam logic [REL_W-1:0] REL_RESET = 17'd6554;

  // Envelope in Q1.16, one is 1 << ENV_FRAC
  localparam int             ENV_W    = 17;
  localparam int             ENV_FRAC = 16;
  localparam logic [ENV_W-1:0] ENV_ONE = 17'd65536;

  // Squares are Q0.(2*SAMPLE_BITS-2), threshold is Q0.30
  localparam int SQ_FRAC = 2 * SAMPLE_BITS - 2;
  localparam int LHS_SH  = (SQ_FRAC >= 30) ? 0 : 30 - SQ_FRAC;
  localparam int RHS_SH  = (SQ_FRAC >= 30) ? SQ_FRAC - 30 : 0;
  localparam int RHS_W   = THR_W + CNT_W + 1;
  localparam int CMP_W   = (SUM_W + LHS_SH > RHS_W + RHS_SH) ? SUM_W + LHS_SH
                                                             : RHS_W + RHS_SH;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_out;
  } gated_t;

  typedef struct packed {
    logic sq_load;
    logic sq_en;
    logic scale_load;
    logic scale_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic add;
    logic start;
    logic clear;
  } merge_ctrl_t;

endpackage

// ----- sv/block_energy_noise_gate_unit.sv -----
// ----------------------------------------------------------------------------
// block_energy_noise_gate_unit
// Block-energy noise gate with attack/release envelope.
// ----------------------------------------------------------------------------
// Frames load at one per cycle into the frame RAM while the left lane, and
// in stereo the right lane, square the samples. A frame marked last, or the
// frame that fills the buffer, ends the block: the input then stalls while
// the merge stage finishes the sum, tests the mean square against the
// threshold and steps the envelope. Each buffered frame is emitted by S_EMIT
// (registered RAM read, waits while a stall holds the output register) and
// S_SCALE (lane multiply). Loading of the next block starts as soon as the
// last gated frame sits in the output register. The frame RAM needs no clear.
module block_energy_noise_gate_unit import beng_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  frame_t           frame,
  output logic             gated_valid,
  input  logic             gated_stall,
  output gated_t           gated,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;

  logic [2:0]        state;
  logic [CHN_W-1:0]  channel_count;
  logic [THR_W-1:0]  threshold;
  logic [ATK_W-1:0]  attack_coeff;
  logic [REL_W-1:0]  release_coeff;
  logic [CNT_W-1:0]  frame_count;
  logic [CNT_W-1:0]  count_inc;
  logic [ADDR_W-1:0] emit_idx;
  logic              add_pend;
  logic              last_q;
  logic              stereo;
  logic              accept;
  logic              block_end;
  logic              emit_last;
  logic [SQ_W-1:0]   rdata;
  logic [SQ_W-1:0]   sq_left;
  logic [SQ_W-1:0]   sq_right;
  logic [ENV_W-1:0]  env;
  logic              env_done;
  lane_ctrl_t        ctl_left;
  lane_ctrl_t        ctl_right;
  merge_ctrl_t       ctl_merge;

  assign stereo      = channel_count[1];
  assign frame_stall = state != S_LOAD;
  assign accept      = frame_valid && !frame_stall;
  assign count_inc   = frame_count + CNT_W'(1);
  assign block_end   = frame.last || (count_inc == CNT_W'(BLOCK_FRAMES));
  assign emit_last   = (CNT_W'(emit_idx) + CNT_W'(1)) == frame_count;

  assign ctl_left  = '{sq_load: accept, sq_en: 1'b1,
                       scale_load: state == S_SCALE, scale_en: 1'b1};
  assign ctl_right = '{sq_load: accept, sq_en: stereo,
                       scale_load: state == S_SCALE, scale_en: stereo};
  assign ctl_merge = '{add: add_pend, start: state == S_START, clear: env_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHN_RESET;
      threshold     <= THR_RESET;
      attack_coeff  <= ATK_RESET;
      release_coeff <= REL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNELS: channel_count <= wr_data[CHN_W-1:0];
        REG_THRESH:   threshold     <= wr_data[THR_W-1:0];
        REG_ATTACK:   attack_coeff  <= wr_data[ATK_W-1:0];
        REG_RELEASE:  release_coeff <= wr_data[REL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      frame_count <= '0;
      emit_idx    <= '0;
      add_pend    <= 1'b0;
      gated_valid <= 1'b0;
    end else begin
      add_pend <= accept;
      if (state == S_SCALE) begin
        gated_valid <= 1'b1;
      end else if (!gated_stall) begin
        gated_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            frame_count <= count_inc;
            if (block_end) begin
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (env_done) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // issue the read only once the output register frees up
          if (!gated_valid || !gated_stall) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (emit_last) begin
            frame_count <= '0;
            state       <= S_LOAD;
          end else begin
            emit_idx <= emit_idx + ADDR_W'(1);
            state    <= S_EMIT;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCALE) begin
      last_q <= emit_last;
    end
  end

  beng_ram #(
    .WIDTH (SQ_W),
    .DEPTH (BLOCK_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (frame_count[ADDR_W-1:0]),
    .wdata ({frame.right_sample, frame.left_sample}),
    .raddr (emit_idx),
    .rdata (rdata)
  );

  beng_lane u_lane_left (
    .clk          (clk),
    .ctl          (ctl_left),
    .sq_sample    (frame.left_sample),
    .scale_sample ($signed(rdata[SAMPLE_BITS-1:0])),
    .env          (env),
    .sq           (sq_left),
    .scaled       (gated.left_out)
  );

  beng_lane u_lane_right (
    .clk          (clk),
    .ctl          (ctl_right),
    .sq_sample    (frame.right_sample),
    .scale_sample ($signed(rdata[SQ_W-1:SAMPLE_BITS])),
    .env          (env),
    .sq           (sq_right),
    .scaled       (gated.right_out)
  );

  beng_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl_merge),
    .sq_left       (sq_left),
    .sq_right      (sq_right),
    .stereo        (stereo),
    .frame_count   (frame_count),
    .threshold     (threshold),
    .attack_coeff  (attack_coeff),
    .release_coeff (release_coeff),
    .env           (env),
    .done          (env_done)
  );

  assign gated.last_out = last_q;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_W'(BLOCK_FRAMES))
    else $error("frame count beyond buffer");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE) |-> !gated_valid)
    else $error("output register overwritten");

  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (accept && frame.last) |=> frame_stall)
    else $error("input not stalled after block end");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE) |-> (frame_count != '0))
    else $error("emission from an empty block");

endmodule

// ----- sv/beng_ram.sv -----
// ----------------------------------------------------------------------------
// beng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module beng_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/beng_lane.sv -----
// ----------------------------------------------------------------------------
// beng_lane
// One channel lane: squares incoming samples and scales stored samples
// by the envelope.
// ----------------------------------------------------------------------------
module beng_lane import beng_pkg::*; (
  input  logic                          clk,
  input  lane_ctrl_t                    ctl,
  input  logic signed [SAMPLE_BITS-1:0] sq_sample,
  input  logic signed [SAMPLE_BITS-1:0] scale_sample,
  input  logic        [ENV_W-1:0]       env,
  output logic        [SQ_W-1:0]        sq,
  output logic signed [SAMPLE_BITS-1:0] scaled
);

  localparam int SCL_W = SAMPLE_BITS + ENV_W + 1;

  logic signed [SQ_W-1:0]  sq_prod;
  logic signed [SCL_W-1:0] sample_ext;
  logic signed [SCL_W-1:0] env_ext;
  logic signed [SCL_W-1:0] scale_prod;
  logic signed [SCL_W-1:0] scale_shift;

  assign sq_prod     = SQ_W'(sq_sample) * SQ_W'(sq_sample);
  assign sample_ext  = SCL_W'(scale_sample);
  assign env_ext     = $signed({{(SCL_W - ENV_W){1'b0}}, env});
  assign scale_prod  = sample_ext * env_ext;
  // arithmetic shift gives the floor
  assign scale_shift = scale_prod >>> ENV_FRAC;

  always_ff @(posedge clk) begin
    if (ctl.sq_load) begin
      sq <= ctl.sq_en ? $unsigned(sq_prod) : '0;
    end
    if (ctl.scale_load) begin
      scaled <= ctl.scale_en ? $signed(scale_shift[SAMPLE_BITS-1:0]) : '0;
    end
  end

endmodule

// ----- sv/beng_merge.sv -----
// ----------------------------------------------------------------------------
// beng_merge
// Merges lane squares into the saturating block sum, runs the threshold
// test and steps the attack/release envelope.
// ----------------------------------------------------------------------------
module beng_merge import beng_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  merge_ctrl_t       ctl,
  input  logic [SQ_W-1:0]   sq_left,
  input  logic [SQ_W-1:0]   sq_right,
  input  logic              stereo,
  input  logic [CNT_W-1:0]  frame_count,
  input  logic [THR_W-1:0]  threshold,
  input  logic [ATK_W-1:0]  attack_coeff,
  input  logic [REL_W-1:0]  release_coeff,
  output logic [ENV_W-1:0]  env,
  output logic              done
);

  localparam int DIFF_W = ENV_W + 1;
  localparam int COEF_W = REL_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int NEW_W  = PROD_W - ENV_FRAC + 1;

  logic [SUM_W-1:0]  square_sum;
  logic [SUM_W:0]    sum_total;
  logic [CNT_W:0]    count_scaled;
  logic [RHS_W-1:0]  rhs_prod;
  logic [RHS_W-1:0]  rhs;
  logic [CMP_W-1:0]  lhs_cmp;
  logic [CMP_W-1:0]  rhs_cmp;
  logic              target_open;
  logic [ENV_W-1:0]  target;
  logic              rising;
  logic [REL_W-1:0]  coeff;
  logic signed [DIFF_W-1:0] diff;
  logic signed [COEF_W-1:0] coeff_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic signed [NEW_W-1:0]  env_s;
  logic signed [NEW_W-1:0]  env_sum;
  logic [ENV_W-1:0]  env_next;
  logic              ph1;
  logic              ph2;
  logic              ph3;

  assign sum_total    = {1'b0, square_sum} + (SUM_W + 1)'(sq_left) + (SUM_W + 1)'(sq_right);
  assign count_scaled = stereo ? {frame_count, 1'b0} : {1'b0, frame_count};
  assign rhs_prod     = RHS_W'(threshold) * RHS_W'(count_scaled);
  assign lhs_cmp      = CMP_W'(square_sum) << LHS_SH;
  assign rhs_cmp      = CMP_W'(rhs) << RHS_SH;

  assign target  = target_open ? ENV_ONE : '0;
  assign rising  = target > env;
  assign coeff   = rising ? REL_W'(attack_coeff) : release_coeff;
  assign diff    = $signed({1'b0, target}) - $signed({1'b0, env});
  assign coeff_s = $signed({1'b0, coeff});

  assign step    = prod >>> ENV_FRAC;
  assign env_s   = $signed({{(NEW_W - ENV_W){1'b0}}, env});
  assign env_sum = env_s + step[NEW_W-1:0];

  // clamp to [0, one]
  always_comb begin
    if (env_sum < 0) begin
      env_next = '0;
    end else if (env_sum > $signed({{(NEW_W - ENV_W){1'b0}}, ENV_ONE})) begin
      env_next = ENV_ONE;
    end else begin
      env_next = env_sum[ENV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      env        <= ENV_ONE;
      ph1        <= 1'b0;
      ph2        <= 1'b0;
      ph3        <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (ctl.clear) begin
        square_sum <= '0;
      end else if (ctl.add) begin
        square_sum <= sum_total[SUM_W] ? '1 : sum_total[SUM_W-1:0];
      end
      ph1  <= ctl.start;
      ph2  <= ph1;
      ph3  <= ph2;
      done <= ph3;
      if (ph3) begin
        env <= env_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rhs <= rhs_prod;
    end
    if (ph1) begin
      target_open <= lhs_cmp > rhs_cmp;
    end
    if (ph2) begin
      prod <= PROD_W'(diff) * PROD_W'(coeff_s);
    end
  end

  a_env_range: assert property (@(posedge clk) disable iff (rst) env <= ENV_ONE)
    else $error("envelope above one");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block-energy noise gate. A tracker class keeps
// its own copy of the frame buffer, square sum, envelope and registers,
// predicts every gated frame from the accepted input frames, and checks the
// gated output in order. Stimulus is a directed pass over the corner cases,
// then random blocks under random register settings, bursty input traffic
// and a patterned output stall.
// ----------------------------------------------------------------------------
import beng_pkg::*;

class gate_tracker;
  logic [CHN_W-1:0]         chn;
  logic [THR_W-1:0]         thr;
  logic [ATK_W-1:0]         atk;
  logic [REL_W-1:0]         rel;
  logic [2*SAMPLE_BITS-1:0] store [BLOCK_FRAMES];
  longint                   energy;
  int                       fill;
  longint                   env;
  gated_t                   due_frames [$];
  int                       errors;

  function new();
    chn    = CHN_RESET;
    thr    = THR_RESET;
    atk    = ATK_RESET;
    rel    = REL_RESET;
    energy = 0;
    fill   = 0;
    env    = longint'(ENV_ONE);
    errors = 0;
  endfunction

  function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_CHANNELS: chn = data[CHN_W-1:0];
      REG_THRESH:   thr = data[THR_W-1:0];
      REG_ATTACK:   atk = data[ATK_W-1:0];
      REG_RELEASE:  rel = data[REL_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due_frames.size();
  endfunction

  function void take_frame(frame_t f);
    longint l, r, sl, sr, lhs, rhs, target, coeff, env_max, energy_max;
    logic   stereo;
    gated_t g;
    stereo     = chn[1];
    env_max    = longint'(ENV_ONE);
    energy_max = (longint'(1) << SUM_W) - 1;
    l = longint'($signed(f.left_sample));
    r = longint'($signed(f.right_sample));
    store[fill] = {f.left_sample, f.right_sample};
    fill++;
    energy += l * l;
    if (stereo) energy += r * r;
    if (energy > energy_max) energy = energy_max;
    if (!f.last && fill < BLOCK_FRAMES) return;

    // compare sum against threshold times sample count, no division
    lhs = energy << LHS_SH;
    rhs = longint'(thr) * longint'(stereo ? 2 * fill : fill);
    rhs = rhs << RHS_SH;
    target = (lhs > rhs) ? env_max : 0;
    coeff  = (target > env) ? longint'(atk) : longint'(rel);
    env    = env + (((target - env) * coeff) >>> ENV_FRAC);
    if (env < 0) env = 0;
    if (env > env_max) env = env_max;

    for (int k = 0; k < fill; k++) begin
      sl = longint'($signed(store[k][2*SAMPLE_BITS-1:SAMPLE_BITS]));
      sr = longint'($signed(store[k][SAMPLE_BITS-1:0]));
      g.left_out  = SAMPLE_BITS'((sl * env) >>> ENV_FRAC);
      g.right_out = stereo ? SAMPLE_BITS'((sr * env) >>> ENV_FRAC) : '0;
      g.last_out  = (k == fill - 1);
      due_frames.push_back(g);
    end
    energy = 0;
    fill   = 0;
  endfunction

  function void check_gated(gated_t got);
    gated_t want;
    if (due_frames.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected gated frame: L=%0d R=%0d last=%0b",
                 $signed(got.left_out), $signed(got.right_out), got.last_out);
      return;
    end
    want = due_frames.pop_front();
    if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
        got.last_out !== want.last_out) begin
      errors++;
      if (errors <= 10)
        $display("gated mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                 $signed(want.left_out), $signed(want.right_out), want.last_out,
                 $signed(got.left_out), $signed(got.right_out), got.last_out);
    end
  endfunction
endclass

module testbench;

  localparam int RANDOM_ITEMS = 290;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {AMP_SILENT, AMP_QUIET, AMP_LOUD, AMP_EDGE} amp_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_e;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  frame_t           frame       = '0;
  logic             gated_valid;
  logic             gated_stall = 1'b0;
  gated_t           gated;
  logic             wr_en       = 1'b0;
  logic [IDX_W-1:0] wr_index    = REG_CHANNELS;
  logic [CFG_W-1:0] wr_data     = '0;

  gate_tracker tracker = new();

  int     items_sent = 0;
  int     burst_left = 0;
  bit     valid_held = 1'b0;
  stall_e stall_mode = STALL_NONE;
  int     seg_left   = 0;

  block_energy_noise_gate_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .gated_valid (gated_valid),
    .gated_stall (gated_stall),
    .gated       (gated),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) tracker.take_frame(frame);
    if (!rst && gated_valid && !gated_stall) tracker.check_gated(gated);
  end

  // output stall: segments of random length, each with its own pattern
  always @(negedge clk) begin
    if (seg_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      seg_left   = $urandom_range(4, 40);
    end
    seg_left--;
    case (stall_mode)
      STALL_NONE:  gated_stall <= 1'b0;
      STALL_LIGHT: gated_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: gated_stall <= ($urandom_range(0, 1) == 0);
      default:     gated_stall <= ((seg_left % 8) < 5);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(amp_e mode);
    case (mode)
      AMP_SILENT: return '0;
      AMP_QUIET:  return SAMPLE_BITS'(int'($urandom_range(0, 1200)) - 600);
      AMP_LOUD:   return SAMPLE_BITS'($urandom);
      default:    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic lower_valid();
    if (valid_held) begin
      frame_valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_frame(input frame_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        lower_valid();
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    frame       <= f;
    frame_valid <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk); while (frame_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_block(input int n, input amp_e mode, input bit end_mark);
    frame_t f;
    for (int k = 0; k < n; k++) begin
      f.left_sample  = pick_sample(mode);
      f.right_sample = pick_sample(mode);
      f.last         = end_mark && (k == n - 1);
      send_frame(f);
    end
  endtask

  // drain every due frame, then let the block finish any buffer write
  task automatic wait_idle();
    lower_valid();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CHN_W-1:0] chn, input logic [THR_W-1:0] thr,
                                input logic [ATK_W-1:0] atk, input logic [REL_W-1:0] rel);
    wait_idle();
    write_reg(REG_CHANNELS, CFG_W'(chn));
    write_reg(REG_THRESH, CFG_W'(thr));
    write_reg(REG_ATTACK, CFG_W'(atk));
    write_reg(REG_RELEASE, CFG_W'(rel));
  endtask

  initial begin
    frame_t           f;
    int               base, len, cut, sel;
    amp_e             mode;
    bit               end_mark;
    logic [CHN_W-1:0] r_chn;
    logic [THR_W-1:0] r_thr;
    logic [ATK_W-1:0] r_atk;
    logic [REL_W-1:0] r_rel;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-frame blocks at both ends of the sample range, then a silent and a loud block, reset settings
    f = '{left_sample: 16'h7fff, right_sample: 16'h7fff, last: 1'b1};
    send_frame(f);
    f = '{left_sample: 16'h8000, right_sample: 16'h8000, last: 1'b1};
    send_frame(f);
    send_block(3, AMP_SILENT, 1'b1);
    send_block(2, AMP_LOUD, 1'b1);

    // mono: right output must come back zero
    apply_settings(2'd1, 27'd1073742, 13'd655, 17'd6554);
    send_block(2, AMP_LOUD, 1'b1);

    // channel change inside a block, both directions
    apply_settings(2'd2, 27'd1073742, 13'd655, 17'd6554);
    send_block(2, AMP_LOUD, 1'b0);
    wait_idle();
    write_reg(REG_CHANNELS, CFG_W'(2'd0));
    send_block(2, AMP_QUIET, 1'b1);
    send_block(2, AMP_LOUD, 1'b0);
    wait_idle();
    write_reg(REG_CHANNELS, CFG_W'(2'd3));
    send_block(1, AMP_LOUD, 1'b1);

    // full buffer of negative full scale: saturates the sum, ends without last
    f = '{left_sample: 16'h8000, right_sample: 16'h8000, last: 1'b0};
    repeat (BLOCK_FRAMES) send_frame(f);

    // release above one clamps the envelope to zero, then largest attack
    apply_settings(2'd2, 27'd107374182, 13'd8191, 17'h1ffff);
    send_block(2, AMP_SILENT, 1'b1);
    send_block(2, AMP_EDGE, 1'b1);
    apply_settings(2'd1, 27'd107374, 13'd66, 17'd65536);
    send_block(3, AMP_QUIET, 1'b1);
    send_block(2, AMP_EDGE, 1'b1);
    apply_settings(2'd2, 27'h7ffffff, 13'd6554, 17'd655);
    send_block(2, AMP_LOUD, 1'b1);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        sel   = $urandom_range(0, 9);
        r_chn = (sel < 7) ? CHN_W'($urandom_range(1, 2)) : CHN_W'($urandom);
        sel   = $urandom_range(0, 5);
        case (sel)
          0:       r_thr = 27'd107374;
          1:       r_thr = 27'd107374182;
          2:       r_thr = THR_RESET;
          3:       r_thr = THR_W'($urandom);
          default: r_thr = THR_W'($urandom_range(107374, 20000000));
        endcase
        sel   = $urandom_range(0, 4);
        r_atk = (sel == 0) ? ATK_W'($urandom) : ATK_W'($urandom_range(66, 6554));
        sel   = $urandom_range(0, 4);
        r_rel = (sel == 0) ? REL_W'($urandom) : REL_W'($urandom_range(655, 65536));
        apply_settings(r_chn, r_thr, r_atk, r_rel);
      end
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) len = $urandom_range(1, 8);
        else if (sel < 18) len = $urandom_range(9, 40);
        else len = BLOCK_FRAMES;
        mode     = amp_e'($urandom_range(0, 3));
        end_mark = (len < BLOCK_FRAMES) ? 1'b1 : bit'($urandom_range(0, 1));
        if (len > 1 && $urandom_range(0, 9) == 0) begin
          // change a setting while the block is partly loaded
          cut = $urandom_range(1, len - 1);
          send_block(cut, mode, 1'b0);
          wait_idle();
          if ($urandom_range(0, 1))
            write_reg(REG_CHANNELS, CFG_W'($urandom_range(0, 3)));
          else
            write_reg(REG_THRESH, CFG_W'($urandom_range(107374, 107374182)));
          send_block(len - cut, mode, end_mark);
        end else begin
          send_block(len, mode, end_mark);
        end
      end
    end

    // close any open block so every buffered frame comes out
    f.left_sample  = pick_sample(AMP_LOUD);
    f.right_sample = pick_sample(AMP_LOUD);
    f.last         = 1'b1;
    send_frame(f);
    lower_valid();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
